// ===== src/kmpd_pkg.sv =====
// Package: shared types and fixed constants of the keyboard/mouse packet decoder.
package kmpd_pkg;

	// Item kinds
	localparam logic KIND_LINK = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_HEADER = 2'd0;
	localparam logic [1:0] REG_MAX_X  = 2'd1;
	localparam logic [1:0] REG_MAX_Y  = 2'd2;

	localparam int unsigned ADDR_W = 4;

	// Register reset values
	localparam logic [7:0] HEADER_RST = 8'd248;
	localparam logic [9:0] MAX_X_RST  = 10'd624;
	localparam logic [9:0] MAX_Y_RST  = 10'd384;

	// Key FIFO command from the decoder
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] wdata;
	} fifo_ctl_t;

	// Key FIFO status back to the decoder
	typedef struct packed {
		logic empty;
		logic full;
		logic one_left;
	} fifo_stat_t;

endpackage

// ===== src/kmpd_if.sv =====
// Interfaces: input item channel and result channel.
interface kmpd_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface kmpd_result_if;
	logic       valid;
	logic       ready;
	logic [9:0] cursor_x;
	logic [9:0] cursor_y;
	logic [9:0] prev_x;
	logic [9:0] prev_y;
	logic       moved;
	logic       key_valid;
	logic [7:0] key_code;
	logic       keys_waiting;
	logic       overflow;

	modport source (output valid, output cursor_x, output cursor_y, output prev_x,
		output prev_y, output moved, output key_valid, output key_code,
		output keys_waiting, output overflow, input ready);
	modport sink   (input valid, input cursor_x, input cursor_y, input prev_x,
		input prev_y, input moved, input key_valid, input key_code,
		input keys_waiting, input overflow, output ready);
endinterface

// ===== src/keyboard_mouse_packet_decoder.sv =====
// Top level: keyboard/mouse link byte decoder with cursor tracking and key FIFO.
//
//  channel   dir  handshake        payload
//  item      in   valid/ready      kind, data_byte
//  result    out  valid/ready      cursor_x/y, prev_x/y, moved, key_valid,
//                                  key_code, keys_waiting, overflow
//  apb       in   psel/penable     paddr, pwdata -> prdata (pready tied high)
//
// One item per cycle while results are taken; each result appears the cycle after
// its item's transfer. The FIFO memory read lands in its output register in step
// with the result register, so pops also sustain one per cycle.
// item.ready is high whenever the result register is empty or being taken.
// Reset clears the cursor, packet phase, moved flag and FIFO pointers; the key
// memory itself is not cleared (entries are only read after being written).
module keyboard_mouse_packet_decoder #(
	parameter int unsigned FIFO_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kmpd_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	kmpd_item_if.sink                      item,
	kmpd_result_if.source                  result
);

	// packet phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_X    = 2'd1;
	localparam logic [1:0] PH_Y    = 2'd2;

	// config registers
	logic [7:0] header_q;
	logic [9:0] max_x_q;
	logic [9:0] max_y_q;

	// decoder state; also drives the cursor fields of the result
	logic [1:0] phase_q;
	logic [9:0] pos_x_q;
	logic [9:0] pos_y_q;
	logic [9:0] last_x_q;
	logic [9:0] last_y_q;
	logic       moved_q;

	// result register
	logic       out_valid_q;
	logic       key_valid_q;
	logic       keys_waiting_q;
	logic       overflow_q;

	logic                 accept;
	logic                 is_link;
	logic                 is_key_byte;
	logic                 do_push;
	logic                 do_pop;
	logic                 dropped;
	logic [11:0]          delta;
	logic [11:0]          sum_x;
	logic [11:0]          sum_y;
	logic [9:0]           raw_x;
	logic [9:0]           raw_y;
	logic [1:0]           phase_d;
	logic [7:0]           fifo_rdata;
	kmpd_pkg::fifo_ctl_t  fifo_ctl;
	kmpd_pkg::fifo_stat_t fifo_stat;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			kmpd_pkg::REG_HEADER: prdata = {24'd0, header_q};
			kmpd_pkg::REG_MAX_X:  prdata = {22'd0, max_x_q};
			kmpd_pkg::REG_MAX_Y:  prdata = {22'd0, max_y_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= kmpd_pkg::HEADER_RST;
			max_x_q  <= kmpd_pkg::MAX_X_RST;
			max_y_q  <= kmpd_pkg::MAX_Y_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				kmpd_pkg::REG_HEADER: header_q <= pwdata[7:0];
				kmpd_pkg::REG_MAX_X:  max_x_q  <= pwdata[9:0];
				kmpd_pkg::REG_MAX_Y:  max_y_q  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// ---------------- decode ----------------
	// the result register frees up the cycle it is taken
	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign is_link    = (item.kind == kmpd_pkg::KIND_LINK);

	// a link byte outside a packet that is not a header is a key code
	assign is_key_byte = is_link && (phase_q != PH_X) && (phase_q != PH_Y) &&
		(item.data_byte != header_q);
	assign do_push = accept && is_key_byte && !fifo_stat.full;
	assign dropped = is_key_byte && fifo_stat.full;
	assign do_pop  = accept && !is_link && !fifo_stat.empty;

	assign fifo_ctl.push  = do_push;
	assign fifo_ctl.pop   = do_pop;
	assign fifo_ctl.wdata = item.data_byte;

	// delta byte is two's complement; floor the sum at zero and saturate it at 1023
	assign delta = {{4{item.data_byte[7]}}, item.data_byte};
	assign sum_x = {2'b00, pos_x_q} + delta;
	assign sum_y = {2'b00, pos_y_q} + delta;

	always_comb begin
		raw_x   = pos_x_q;
		raw_y   = pos_y_q;
		phase_d = PH_IDLE;
		case (phase_q)
			PH_X: begin
				raw_x   = sum_x[11] ? 10'd0 : (sum_x[10] ? 10'h3FF : sum_x[9:0]);
				phase_d = PH_Y;
			end
			PH_Y: begin
				raw_y   = sum_y[11] ? 10'd0 : (sum_y[10] ? 10'h3FF : sum_y[9:0]);
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = (item.data_byte == header_q) ? PH_X : PH_IDLE;
			end
		endcase
	end

	// state and result register; link bytes clamp both axes to the limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			moved_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			key_valid_q    <= 1'b0;
			keys_waiting_q <= 1'b0;
			overflow_q     <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				key_valid_q    <= do_pop;
				overflow_q     <= dropped;
				keys_waiting_q <= do_push ||
					(!fifo_stat.empty && !(do_pop && fifo_stat.one_left));
				if (is_link) begin
					phase_q <= phase_d;
					pos_x_q <= (raw_x > max_x_q) ? max_x_q : raw_x;
					pos_y_q <= (raw_y > max_y_q) ? max_y_q : raw_y;
					if (phase_q == PH_X) begin
						last_x_q <= pos_x_q;
					end
					if (phase_q == PH_Y) begin
						last_y_q <= pos_y_q;
					end
					if (phase_q != PH_X && phase_q != PH_Y &&
						item.data_byte == header_q) begin
						moved_q <= 1'b1;
					end
				end
			end
		end
	end

	kmpd_key_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_key_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.rdata  (fifo_rdata),
		.stat   (fifo_stat)
	);

	// ---------------- result ----------------
	assign result.valid        = out_valid_q;
	assign result.cursor_x     = pos_x_q;
	assign result.cursor_y     = pos_y_q;
	assign result.prev_x       = last_x_q;
	assign result.prev_y       = last_y_q;
	assign result.moved        = moved_q;
	assign result.key_valid    = key_valid_q;
	assign result.key_code     = key_valid_q ? fifo_rdata : 8'd0;
	assign result.keys_waiting = keys_waiting_q;
	assign result.overflow     = overflow_q;

	// ---------------- assertions ----------------
	a_pop_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && key_valid_q) |-> !overflow_q)
		else $error("key returned and overflow flagged together");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_link && fifo_stat.empty) |=> !key_valid_q)
		else $error("pop on empty FIFO returned a key");

	a_x_then_y: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_link && phase_q == PH_X) |=> (phase_q == PH_Y))
		else $error("X delta not followed by Y phase");

	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_link) |=> (pos_x_q <= $past(max_x_q)))
		else $error("cursor x above limit after link byte");

endmodule

// ===== src/kmpd_key_fifo.sv =====
// Key FIFO: simple dual-port synchronous memory with wrap pointers and a fill count.
module kmpd_key_fifo #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kmpd_pkg::fifo_ctl_t   ctl,
	output logic [7:0]            rdata,
	output kmpd_pkg::fifo_stat_t  stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       rdata_q;

	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_FULL);
	assign stat.one_left = (count_q == CNT_W'(1));
	assign rdata         = rdata_q;

	// caller only issues push when not full, pop when not empty
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr_q] <= ctl.wdata;
		end
		if (ctl.pop) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
